// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg
// shared constants, types and state codes of the projection profile band finder
// ----------------------------------------------------------------------------
package pbf_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int VALUE_BITS = 20;
  localparam int MAX_BANDS  = 64;

  // profile store address and position widths
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int POS_W   = $clog2(MAX_LEN + 2);
  // band store
  localparam int BAND_AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CNT_W   = $clog2(MAX_BANDS + 1);

  // fixed port widths
  localparam int START_W   = 12;
  localparam int END_W     = 13;
  localparam int RUN_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN   = 2'd1;

  // register reset values
  localparam logic             AXIS_MODE_RST = 1'b1;
  localparam logic [RUN_W-1:0] MIN_RUN_RST   = 13'd8;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_SCAN,
    PH_WRAP,
    PH_BANDS
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [POS_W-1:0]  stop;
  } band_t;

  typedef struct packed {
    logic               en;
    logic [BAND_AW-1:0] addr;
    band_t              data;
  } band_wr_t;

  typedef struct packed {
    logic             any_text;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] lend;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } scan_stat_t;

endpackage

// ===== rtl/projection_profile_band_finder_top.sv =====
// ----------------------------------------------------------------------------
// projection_profile_band_finder_top
// finds text bands or the text span in one projection profile of a page
// ----------------------------------------------------------------------------
// A profile is loaded one value per start transaction while busy is low; the
// value with last_value set closes the profile. Busy then rises for the
// processing: a scan of the stored profile reads positions 0..n (n = stored
// length, one read of the profile memory per cycle through a registered read,
// the extra position closes a run), followed in row mode with bands by a
// readout that reads the band memory and sends one band per cycle. No new
// profile is taken until this processing is done. Results appear on the span ports
// for one cycle each with span_valid high and cannot be held off by the
// receiver. Values past the store depth are dropped, but last_value still
// closes the profile. The store needs no clearing after reset. Configuration
// is written through cfg_valid / cfg_ready (always ready) and should only
// change while the block is idle.
// ----------------------------------------------------------------------------
module projection_profile_band_finder_top (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic [pbf_pkg::VALUE_BITS-1:0]    profile_value,
  input  logic                              last_value,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbf_pkg::CFG_DAT_W-1:0]     cfg_data,
  // result channel
  output logic                              span_valid,
  output logic [pbf_pkg::START_W-1:0]       span_start,
  output logic [pbf_pkg::END_W-1:0]         span_end,
  output logic                              span_found,
  output logic                              band_overflow,
  output logic                              last_span
);

  // configuration registers
  logic                      axis_mode;
  logic [pbf_pkg::RUN_W-1:0] min_run;

  // control state
  pbf_pkg::phase_t phase, phase_next;

  // load side
  logic [pbf_pkg::POS_W-1:0]      count;
  logic [pbf_pkg::VALUE_BITS-1:0] peak;
  logic [pbf_pkg::POS_W-1:0]      n_len;
  logic [pbf_pkg::VALUE_BITS-1:0] pk;

  // memories
  logic [pbf_pkg::VALUE_BITS-1:0] prof_mem [pbf_pkg::MAX_LEN];
  pbf_pkg::band_t                 band_mem [pbf_pkg::MAX_BANDS];

  // scan pipeline
  logic [pbf_pkg::POS_W-1:0]      sidx;
  logic                           pvalid;
  logic [pbf_pkg::POS_W-1:0]      pidx;
  logic [pbf_pkg::VALUE_BITS-1:0] prof_q;

  // band readout pipeline
  logic [pbf_pkg::CNT_W-1:0] bidx;
  logic                      bvalid;
  logic [pbf_pkg::CNT_W-1:0] bpidx;
  pbf_pkg::band_t            band_q;

  // result registers and their next values
  logic                        span_valid_next;
  logic [pbf_pkg::START_W-1:0] span_start_next;
  logic [pbf_pkg::END_W-1:0]   span_end_next;
  logic                        span_found_next;
  logic                        band_overflow_next;
  logic                        last_span_next;

  logic accept;
  logic store_ok;
  logic profile_done;
  logic rd_en;
  logic b_rd;
  logic mark_text;
  logic scan_end;
  logic band_last;
  logic bands_out;

  pbf_pkg::band_wr_t   band_wr;
  pbf_pkg::scan_stat_t stat;

  // column span edges after gap filling
  logic [pbf_pkg::POS_W-1:0] col_first;
  logic [pbf_pkg::POS_W-1:0] col_end;
  logic [pbf_pkg::POS_W-1:0] tail_gap;

  assign busy         = (phase != pbf_pkg::PH_LOAD);
  assign cfg_ready    = 1'b1;
  assign accept       = start && !busy;
  assign store_ok     = 32'(count) < pbf_pkg::MAX_LEN;
  assign profile_done = accept && last_value;

  // scan reads positions 0..n, the extra position closes a run at the end
  assign rd_en     = (phase == pbf_pkg::PH_SCAN) && (sidx <= n_len);
  assign mark_text = (pidx < n_len) && (prof_q < pk);
  assign scan_end  = pvalid && (pidx == n_len);

  assign b_rd      = (phase == pbf_pkg::PH_BANDS) && (bidx < stat.cnt);
  assign band_last = bvalid && (bpidx == stat.cnt - 1'b1);
  assign bands_out = axis_mode && (stat.cnt != '0);

  // ------------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode <= pbf_pkg::AXIS_MODE_RST;
      min_run   <= pbf_pkg::MIN_RUN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbf_pkg::CFG_AXIS_MODE: axis_mode <= cfg_data[0];
        pbf_pkg::CFG_MIN_RUN:   min_run   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // load: store each value and track the running peak
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      prof_mem[count[pbf_pkg::ADDR_W-1:0]] <= profile_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      peak  <= '0;
      n_len <= '0;
      pk    <= '0;
    end else if (accept) begin
      if (last_value) begin
        // profile closes: freeze length and peak for the scan
        n_len <= store_ok ? count + 1'b1 : count;
        pk    <= (store_ok && (profile_value > peak)) ? profile_value : peak;
        count <= '0;
        peak  <= '0;
      end else if (store_ok) begin
        count <= count + 1'b1;
        if (profile_value > peak) begin
          peak <= profile_value;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // scan: one profile read per cycle, text mark is value below peak
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rd_en) begin
      prof_q <= prof_mem[sidx[pbf_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sidx   <= '0;
      pvalid <= 1'b0;
      pidx   <= '0;
    end else begin
      pvalid <= rd_en;
      if (profile_done) begin
        sidx <= '0;
      end else if (rd_en) begin
        sidx <= sidx + 1'b1;
        pidx <= sidx;
      end
    end
  end

  pbf_run_scan u_run_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (profile_done),
    .mark_valid (pvalid),
    .mark_pos   (pidx),
    .mark_text  (mark_text),
    .axis_mode  (axis_mode),
    .min_run    (min_run),
    .band_wr    (band_wr),
    .stat       (stat)
  );

  // kept bands land here in order
  always_ff @(posedge clk) begin
    if (band_wr.en) begin
      band_mem[band_wr.addr] <= band_wr.data;
    end
  end

  // ------------------------------------------------------------------------
  // band readout
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (b_rd) begin
      band_q <= band_mem[bidx[pbf_pkg::BAND_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bidx   <= '0;
      bvalid <= 1'b0;
      bpidx  <= '0;
    end else begin
      bvalid <= b_rd;
      if (phase == pbf_pkg::PH_WRAP) begin
        bidx <= '0;
      end else if (b_rd) begin
        bidx  <= bidx + 1'b1;
        bpidx <= bidx;
      end
    end
  end

  // ------------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    case (phase)
      pbf_pkg::PH_LOAD: begin
        if (profile_done) begin
          phase_next = pbf_pkg::PH_SCAN;
        end
      end
      pbf_pkg::PH_SCAN: begin
        if (scan_end) begin
          phase_next = pbf_pkg::PH_WRAP;
        end
      end
      pbf_pkg::PH_WRAP: begin
        phase_next = bands_out ? pbf_pkg::PH_BANDS : pbf_pkg::PH_LOAD;
      end
      pbf_pkg::PH_BANDS: begin
        if (band_last) begin
          phase_next = pbf_pkg::PH_LOAD;
        end
      end
      default: phase_next = pbf_pkg::PH_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pbf_pkg::PH_LOAD;
    end else begin
      phase <= phase_next;
    end
  end

  // ------------------------------------------------------------------------
  // outputs
  // ------------------------------------------------------------------------
  // column mode: a short leading gap pulls the start to 0, a short trailing
  // gap pushes the end to the profile length
  assign tail_gap  = n_len - stat.lend;
  assign col_first = (32'(stat.first) <= 32'(min_run)) ? '0 : stat.first;
  assign col_end   = (32'(tail_gap) <= 32'(min_run)) ? n_len : stat.lend;

  always_comb begin
    span_valid_next    = 1'b0;
    span_start_next    = '0;
    span_end_next      = '0;
    span_found_next    = 1'b0;
    band_overflow_next = 1'b0;
    last_span_next     = 1'b0;
    case (phase)
      pbf_pkg::PH_WRAP: begin
        // single result: column span or not-found
        if (!bands_out) begin
          span_valid_next = 1'b1;
          last_span_next  = 1'b1;
          if (!axis_mode && stat.any_text) begin
            span_found_next = 1'b1;
            span_start_next = col_first[pbf_pkg::START_W-1:0];
            span_end_next   = col_end[pbf_pkg::END_W-1:0];
          end
        end
      end
      pbf_pkg::PH_BANDS: begin
        if (bvalid) begin
          span_valid_next    = 1'b1;
          span_found_next    = 1'b1;
          span_start_next    = band_q.start[pbf_pkg::START_W-1:0];
          span_end_next      = band_q.stop[pbf_pkg::END_W-1:0];
          band_overflow_next = stat.ovf;
          last_span_next     = band_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else begin
      span_valid <= span_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    span_start    <= span_start_next;
    span_end      <= span_end_next;
    span_found    <= span_found_next;
    band_overflow <= band_overflow_next;
    last_span     <= last_span_next;
  end

endmodule

// ===== rtl/pbf_run_scan.sv =====
// ----------------------------------------------------------------------------
// pbf_run_scan
// run tracker over the streamed text marks: band records and column extent
// ----------------------------------------------------------------------------
module pbf_run_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          mark_valid,
  input  logic [pbf_pkg::POS_W-1:0]     mark_pos,
  input  logic                          mark_text,
  input  logic                          axis_mode,
  input  logic [pbf_pkg::RUN_W-1:0]     min_run,
  output pbf_pkg::band_wr_t             band_wr,
  output pbf_pkg::scan_stat_t           stat
);

  logic                      prev_text;
  logic [pbf_pkg::POS_W-1:0] run_start;
  pbf_pkg::scan_stat_t       st;

  logic [pbf_pkg::POS_W-1:0] run_len;
  logic                      run_close;
  logic                      run_long;
  logic                      room;

  assign run_len   = mark_pos - run_start;
  assign run_close = mark_valid && !mark_text && prev_text && axis_mode;
  assign run_long  = 32'(run_len) > 32'(min_run);
  assign room      = 32'(st.cnt) < pbf_pkg::MAX_BANDS;

  always_comb begin
    band_wr            = '0;
    band_wr.en         = run_close && run_long && room;
    band_wr.addr       = st.cnt[pbf_pkg::BAND_AW-1:0];
    band_wr.data.start = run_start[pbf_pkg::ADDR_W-1:0];
    band_wr.data.stop  = mark_pos;
  end

  assign stat = st;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev_text <= 1'b0;
      run_start <= '0;
      st        <= '0;
    end else if (mark_valid) begin
      prev_text <= mark_text;
      if (mark_text && !prev_text) begin
        run_start <= mark_pos;
      end
      if (mark_text) begin
        st.any_text <= 1'b1;
        if (!st.any_text) begin
          st.first <= mark_pos;
        end
        st.lend <= mark_pos + 1'b1;
      end
      // a text run ended: keep it as a band if long enough
      if (run_close && run_long) begin
        if (room) begin
          st.cnt <= st.cnt + 1'b1;
        end else begin
          st.ovf <= 1'b1;
        end
      end
    end
  end

endmodule
